>>> design/septok_pkg.sv
// shared types and constants for the separator tokenizer
`timescale 1ns / 1ps

package septok_pkg;

   // field widths of the ports
   localparam int BYTE_BITS     = 8;
   localparam int FIELD_BITS    = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam int SEP_SET_SIZE  = 256;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SEP_0_63    = 3'd0,
      CSR_SEP_64_127  = 3'd1,
      CSR_SEP_128_191 = 3'd2,
      CSR_SEP_192_255 = 3'd3,
      CSR_TRIM        = 3'd4,
      CSR_DROP_EMPTY  = 3'd5
   } csr_index_type;

   // c whitespace byte codes
   localparam logic [BYTE_BITS-1:0] WS_SPACE = 8'h20;
   localparam logic [BYTE_BITS-1:0] WS_TAB   = 8'h09;
   localparam logic [BYTE_BITS-1:0] WS_CR    = 8'h0D;

   // whitespace test: space or tab through carriage return
   function automatic logic is_space(input logic [BYTE_BITS-1:0] b);
      is_space = (b == WS_SPACE) || ((b >= WS_TAB) && (b <= WS_CR));
   endfunction

endpackage

>>> design/separator_tokenizer_with_trim_top.sv
// Separator tokenizer: splits a byte stream into tokens at configured separator bytes,
// with optional whitespace trim and empty-token drop. One string byte is taken per cycle,
// sustained, with back-to-back items on the req channel, unless rsp_stall holds the result
// register full. A token passes from an input register through one pass of bitmap lookup
// and offset update into the result register. A byte gives at most one token. Offsets count
// in OFFSET_BITS and saturate at the top, which raises overflow on every token until the
// string's final byte. The user must write configuration through the csr port only while
// no item is in flight; the block does not enforce this. No clearing pass follows reset.
`timescale 1ns / 1ps

module separator_tokenizer_with_trim_top #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // item input
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [septok_pkg::BYTE_BITS-1:0]       req_text_byte,
   input  logic                                   req_final_byte,
   // token output
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [septok_pkg::FIELD_BITS-1:0]      rsp_token_offset,
   output logic [septok_pkg::FIELD_BITS-1:0]      rsp_token_length,
   output logic                                   rsp_closes_string,
   output logic                                   rsp_overflow,
   // configuration writes
   input  logic                                   csr_write,
   input  logic [septok_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [septok_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import septok_pkg::*;

   localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};

   // configuration registers
   logic [SEP_SET_SIZE-1:0]  sep_set_ff, sep_set_in;
   logic                     trim_ff, trim_in;
   logic                     drop_empty_ff, drop_empty_in;

   // input register
   logic                     in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0]     in_byte_ff, in_byte_in;
   logic                     in_final_ff, in_final_in;

   // string state
   logic [OFFSET_BITS-1:0]   position_ff, position_in;
   logic [OFFSET_BITS-1:0]   token_start_ff, token_start_in;
   logic [OFFSET_BITS-1:0]   content_end_ff, content_end_in;
   logic                     skip_lead_ff, skip_lead_in;
   logic                     saturated_ff, saturated_in;

   // result register
   logic                     out_valid_ff, out_valid_in;
   logic [FIELD_BITS-1:0]    out_offset_ff, out_offset_in;
   logic [FIELD_BITS-1:0]    out_length_ff, out_length_in;
   logic                     out_closes_ff, out_closes_in;
   logic                     out_overflow_ff, out_overflow_in;

   // datapath signals
   logic                     advance;
   logic                     fire;
   logic                     byte_ws;
   logic                     byte_sep;
   logic [OFFSET_BITS-1:0]   next_pos;
   logic                     sat_now;
   logic                     report;
   logic [OFFSET_BITS-1:0]   emit_start;
   logic [OFFSET_BITS-1:0]   emit_end;
   logic                     emit_closes;
   logic [OFFSET_BITS-1:0]   emit_len;
   logic                     emit_ok;

   // handshake: the input stage moves whenever the result register can take a new token
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // configuration write decode
   always_comb begin
      sep_set_in    = sep_set_ff;
      trim_in       = trim_ff;
      drop_empty_in = drop_empty_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SEP_0_63:    sep_set_in[63:0]    = csr_wdata;
            CSR_SEP_64_127:  sep_set_in[127:64]  = csr_wdata;
            CSR_SEP_128_191: sep_set_in[191:128] = csr_wdata;
            CSR_SEP_192_255: sep_set_in[255:192] = csr_wdata;
            CSR_TRIM:        trim_in             = csr_wdata[0];
            CSR_DROP_EMPTY:  drop_empty_in       = csr_wdata[0];
            default:         ;
         endcase
      end
   end

   // input register load
   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      in_byte_in  = in_byte_ff;
      in_final_in = in_final_ff;
      if (req_valid && !req_stall) begin
         in_byte_in  = req_text_byte;
         in_final_in = req_final_byte;
      end
   end

   // byte classification and next offset
   assign byte_ws  = is_space(in_byte_ff);
   assign byte_sep = sep_set_ff[in_byte_ff];
   assign sat_now  = (position_ff == OFS_MAX);
   assign next_pos = sat_now ? OFS_MAX : position_ff + 1'b1;

   // token tracking for one byte
   always_comb begin
      position_in    = position_ff;
      token_start_in = token_start_ff;
      content_end_in = content_end_ff;
      skip_lead_in   = skip_lead_ff;
      saturated_in   = saturated_ff | sat_now;
      report         = 1'b0;
      emit_start     = token_start_ff;
      emit_end       = next_pos;
      emit_closes    = 1'b1;
      priority if (skip_lead_ff && trim_ff && byte_ws) begin
         // leading whitespace is eaten, even when it is a separator
         token_start_in = next_pos;
         content_end_in = next_pos;
         emit_start     = next_pos;
         emit_end       = next_pos;
         report         = in_final_ff;
      end else if (byte_sep) begin
         // separator closes the open token and arms the leading skip
         skip_lead_in   = 1'b1;
         token_start_in = next_pos;
         content_end_in = next_pos;
         emit_end       = trim_ff ? content_end_ff : position_ff;
         emit_closes    = in_final_ff;
         report         = 1'b1;
      end else begin
         // token body byte
         skip_lead_in = 1'b0;
         if (!byte_ws) begin
            content_end_in = next_pos;
         end
         emit_end = trim_ff ? content_end_in : next_pos;
         report   = in_final_ff;
      end
      position_in = next_pos;
      // final byte returns the string state to its start values
      if (in_final_ff) begin
         position_in    = '0;
         token_start_in = '0;
         content_end_in = '0;
         skip_lead_in   = 1'b1;
         saturated_in   = 1'b0;
      end
   end

   // token length, clamped at zero
   assign emit_len = (emit_end < emit_start) ? '0 : emit_end - emit_start;
   assign emit_ok  = report && !(drop_empty_ff && (emit_len == '0));

   // result register load
   always_comb begin
      out_valid_in    = out_valid_ff && rsp_stall;
      out_offset_in   = out_offset_ff;
      out_length_in   = out_length_ff;
      out_closes_in   = out_closes_ff;
      out_overflow_in = out_overflow_ff;
      if (fire) begin
         out_valid_in = emit_ok;
         if (emit_ok) begin
            out_offset_in   = FIELD_BITS'(emit_start);
            out_length_in   = FIELD_BITS'(emit_len);
            out_closes_in   = emit_closes;
            out_overflow_in = saturated_ff | sat_now;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_set_ff     <= '0;
         trim_ff        <= 1'b0;
         drop_empty_ff  <= 1'b0;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         position_ff    <= '0;
         token_start_ff <= '0;
         content_end_ff <= '0;
         skip_lead_ff   <= 1'b1;
         saturated_ff   <= 1'b0;
      end else begin
         sep_set_ff    <= sep_set_in;
         trim_ff       <= trim_in;
         drop_empty_ff <= drop_empty_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         if (fire) begin
            position_ff    <= position_in;
            token_start_ff <= token_start_in;
            content_end_ff <= content_end_in;
            skip_lead_ff   <= skip_lead_in;
            saturated_ff   <= saturated_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff      <= in_byte_in;
      in_final_ff     <= in_final_in;
      out_offset_ff   <= out_offset_in;
      out_length_ff   <= out_length_in;
      out_closes_ff   <= out_closes_in;
      out_overflow_ff <= out_overflow_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_token_offset  = out_offset_ff;
   assign rsp_token_length  = out_length_ff;
   assign rsp_closes_string = out_closes_ff;
   assign rsp_overflow      = out_overflow_ff;

`ifndef SYNTHESIS
   // final byte leaves the string state at its start values
   a_string_restart: assert property (@(posedge clock) disable iff (reset)
      fire && in_final_ff |=> position_ff == '0 && skip_lead_ff && !saturated_ff)
      else $error("string state not restarted after final byte");

   // token start and trimmed end never run ahead of the byte offset
   a_offsets_order: assert property (@(posedge clock) disable iff (reset)
      token_start_ff <= position_ff && content_end_ff <= position_ff)
      else $error("token offsets beyond byte position");

   // saturation is only flagged with the offset pinned at its top
   a_saturation: assert property (@(posedge clock) disable iff (reset)
      saturated_ff |-> position_ff == OFS_MAX)
      else $error("saturation flag without saturated offset");

   // a stalled input stage keeps its item
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_final_ff))
      else $error("input item lost while stalled");
`endif

endmodule

>>> tb/separator_tokenizer_with_trim_checker.sv
// token predictor and result checker for the separator tokenizer
`timescale 1ns / 1ps

module separator_tokenizer_with_trim_checker #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [septok_pkg::BYTE_BITS-1:0]      req_text_byte,
   input  logic                                  req_final_byte,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [septok_pkg::FIELD_BITS-1:0]     rsp_token_offset,
   input  logic [septok_pkg::FIELD_BITS-1:0]     rsp_token_length,
   input  logic                                  rsp_closes_string,
   input  logic                                  rsp_overflow,
   input  logic                                  csr_write,
   input  logic [septok_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [septok_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                    outstanding,
   output int                                    fail_count
);
   import septok_pkg::*;

   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

   typedef struct packed {
      logic [FIELD_BITS-1:0] tok_offset;
      logic [FIELD_BITS-1:0] tok_length;
      logic                  tok_closes;
      logic                  tok_overflow;
   } token_type;

   // configuration copy
   logic [63:0] sep_map [4];
   logic        trim_on;
   logic        drop_on;

   // string state
   logic [OFFSET_BITS-1:0] byte_pos;
   logic [OFFSET_BITS-1:0] tok_start;
   logic [OFFSET_BITS-1:0] content_end;
   logic                   skip_lead;
   logic                   saturated;

   token_type expected_tokens [$];
   int        errors = 0;

   // c whitespace: space, tab through carriage return
   function automatic bit is_blank(input logic [BYTE_BITS-1:0] b);
      return (b == WS_SPACE) || (b >= WS_TAB && b <= WS_CR);
   endfunction

   // token from the current start up to stop; 0 when dropped as empty
   function automatic bit make_token(input logic [OFFSET_BITS-1:0] stop, input logic closes,
                                     output token_type tok);
      logic [OFFSET_BITS-1:0] len;
      len = (stop < tok_start) ? '0 : stop - tok_start;
      tok = '0;
      if (drop_on && len == '0)
         return 0;
      tok.tok_offset   = FIELD_BITS'(tok_start);
      tok.tok_length   = FIELD_BITS'(len);
      tok.tok_closes   = closes;
      tok.tok_overflow = saturated;
      return 1;
   endfunction

   function automatic void clear_string();
      byte_pos    = '0;
      tok_start   = '0;
      content_end = '0;
      skip_lead   = 1'b1;
      saturated   = 1'b0;
   endfunction

   // advance the string state by one byte; 1 when a token comes out
   function automatic bit predict_token(input logic [BYTE_BITS-1:0] b, input logic fin,
                                        output token_type tok);
      logic [OFFSET_BITS-1:0] here;
      logic [OFFSET_BITS-1:0] nxt;
      bit                     have;
      have = 0;
      tok  = '0;
      here = byte_pos;
      if (here == POS_MAX) begin
         nxt       = POS_MAX;
         saturated = 1'b1;
      end else begin
         nxt = here + 1'b1;
      end

      if (skip_lead && trim_on && is_blank(b)) begin
         // leading whitespace eaten, even when it is a separator
         tok_start   = nxt;
         content_end = nxt;
         if (fin)
            have = make_token(nxt, 1'b1, tok);
      end else begin
         skip_lead = 1'b0;
         if (sep_map[b[7:6]][b[5:0]]) begin
            have        = make_token(trim_on ? content_end : here, fin, tok);
            tok_start   = nxt;
            content_end = nxt;
            skip_lead   = 1'b1;
         end else begin
            if (!is_blank(b))
               content_end = nxt;
            if (fin)
               have = make_token(trim_on ? content_end : nxt, 1'b1, tok);
         end
      end

      if (fin)
         clear_string();
      else
         byte_pos = nxt;
      return have;
   endfunction

   always @(posedge clock) begin
      token_type got;
      token_type want;
      token_type tok;
      if (reset) begin
         sep_map = '{default: '0};
         trim_on = 1'b0;
         drop_on = 1'b0;
         clear_string();
         expected_tokens.delete();
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index)
               CSR_SEP_0_63:    sep_map[0] = csr_wdata;
               CSR_SEP_64_127:  sep_map[1] = csr_wdata;
               CSR_SEP_128_191: sep_map[2] = csr_wdata;
               CSR_SEP_192_255: sep_map[3] = csr_wdata;
               CSR_TRIM:        trim_on = csr_wdata[0];
               CSR_DROP_EMPTY:  drop_on = csr_wdata[0];
               default: ;
            endcase
         end

         // compare an accepted token with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            got.tok_offset   = rsp_token_offset;
            got.tok_length   = rsp_token_length;
            got.tok_closes   = rsp_closes_string;
            got.tok_overflow = rsp_overflow;
            if (expected_tokens.size() == 0) begin
               errors++;
               $display("%0t unexpected token: offset %0d length %0d closes %0b overflow %0b",
                        $time, got.tok_offset, got.tok_length, got.tok_closes,
                        got.tok_overflow);
            end else begin
               want = expected_tokens.pop_front();
               if (got.tok_offset !== want.tok_offset) begin
                  errors++;
                  $display("%0t token_offset: expected %0d actual %0d",
                           $time, want.tok_offset, got.tok_offset);
               end
               if (got.tok_length !== want.tok_length) begin
                  errors++;
                  $display("%0t token_length: expected %0d actual %0d",
                           $time, want.tok_length, got.tok_length);
               end
               if (got.tok_closes !== want.tok_closes) begin
                  errors++;
                  $display("%0t closes_string: expected %0b actual %0b",
                           $time, want.tok_closes, got.tok_closes);
               end
               if (got.tok_overflow !== want.tok_overflow) begin
                  errors++;
                  $display("%0t overflow: expected %0b actual %0b",
                           $time, want.tok_overflow, got.tok_overflow);
               end
            end
         end

         // predict the token of an accepted byte
         if (req_valid && !req_stall) begin
            if (predict_token(req_text_byte, req_final_byte, tok))
               expected_tokens.insert(expected_tokens.size(), tok);
         end
      end
      outstanding <= expected_tokens.size();
      fail_count  <= errors;
   end

endmodule

>>> tb/separator_tokenizer_with_trim_top_tb.sv
// stimulus, flow control and verdict for the separator tokenizer
`timescale 1ns / 1ps

module separator_tokenizer_with_trim_top_tb;
   import septok_pkg::*;

   localparam int OFFSET_BITS       = 16;
   localparam int RANDOM_PHASES     = 8;

   // indexes past the register list, written to check they are ignored
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_7 = 3'd7;

   localparam logic [BYTE_BITS-1:0] CHR_NUL   = 8'h00;
   localparam logic [BYTE_BITS-1:0] CHR_LF    = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHR_COMMA = 8'h2C;
   localparam logic [BYTE_BITS-1:0] CHR_A     = 8'h61;
   localparam logic [BYTE_BITS-1:0] CHR_B     = 8'h62;
   localparam logic [BYTE_BITS-1:0] CHR_X     = 8'h78;
   localparam logic [BYTE_BITS-1:0] CHR_HIGH  = 8'h85;
   localparam logic [BYTE_BITS-1:0] CHR_TOP   = 8'hFF;

   typedef enum {FLOW_OPEN, FLOW_COIN, FLOW_HEAVY, FLOW_HOLD} flow_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [BYTE_BITS-1:0]     req_text_byte = '0;
   logic                     req_final_byte = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [FIELD_BITS-1:0]    rsp_token_offset;
   logic [FIELD_BITS-1:0]    rsp_token_length;
   logic                     rsp_closes_string;
   logic                     rsp_overflow;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int outstanding;
   int fail_count;

   // sender burst shaping
   int burst_left = 0;
   int burst_min  = 1;
   int burst_max  = 16;
   int gap_max    = 0;

   // separator set as last written, for picking separator bytes
   logic [63:0] sep_copy [4] = '{default: '0};

   // receiver stall pattern state
   flow_mode_type flow_mode = FLOW_OPEN;
   int            flow_left = 0;

   separator_tokenizer_with_trim_top #(
      .OFFSET_BITS(OFFSET_BITS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .req_final_byte    (req_final_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_offset  (rsp_token_offset),
      .rsp_token_length  (rsp_token_length),
      .rsp_closes_string (rsp_closes_string),
      .rsp_overflow      (rsp_overflow),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   separator_tokenizer_with_trim_checker #(
      .OFFSET_BITS(OFFSET_BITS)
   ) token_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .req_final_byte    (req_final_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_offset  (rsp_token_offset),
      .rsp_token_length  (rsp_token_length),
      .rsp_closes_string (rsp_closes_string),
      .rsp_overflow      (rsp_overflow),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .outstanding       (outstanding),
      .fail_count        (fail_count)
   );

   always #5 clock = ~clock;

   // receiver: runs of open flow, coin-flip stalls, heavy stalls and solid holds
   always @(posedge clock) begin
      if (flow_left == 0) begin
         flow_mode = flow_mode_type'($urandom_range(0, 3));
         flow_left = (flow_mode == FLOW_HOLD) ? $urandom_range(1, 8) : $urandom_range(4, 40);
      end
      flow_left--;
      case (flow_mode)
         FLOW_OPEN:  rsp_stall <= 1'b0;
         FLOW_COIN:  rsp_stall <= ($urandom_range(0, 1) == 1);
         FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:    rsp_stall <= 1'b1;
      endcase
   end

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      if (idx <= CSR_SEP_192_255)
         sep_copy[idx[1:0]] = data;
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // all six registers; flag registers get random upper bits
   task automatic load_config(input logic [63:0] m0, input logic [63:0] m1,
                              input logic [63:0] m2, input logic [63:0] m3,
                              input logic trim, input logic drop);
      logic [63:0] junk;
      write_csr(CSR_SEP_0_63, m0);
      write_csr(CSR_SEP_64_127, m1);
      write_csr(CSR_SEP_128_191, m2);
      write_csr(CSR_SEP_192_255, m3);
      junk = {$urandom, $urandom};
      write_csr(CSR_TRIM, {junk[63:1], trim});
      junk = {$urandom, $urandom};
      write_csr(CSR_DROP_EMPTY, {junk[63:1], drop});
   endtask

   // one byte, with a random gap at the start of each burst
   task automatic send_item(input logic [BYTE_BITS-1:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(burst_min, burst_max);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_text_byte  <= b;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold off until every token is back, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_map(input int style);
      logic [63:0] m;
      logic [5:0]  pos;
      case (style)
         0: m = '0;
         1: m = '1;
         2: m = {$urandom, $urandom};
         default: begin
            m = '0;
            repeat ($urandom_range(1, 4)) begin
               pos    = 6'($urandom_range(0, 63));
               m[pos] = 1'b1;
            end
         end
      endcase
      return m;
   endfunction

   // mix of separators, whitespace and arbitrary bytes
   function automatic logic [BYTE_BITS-1:0] pick_byte();
      logic [BYTE_BITS-1:0] b;
      int r;
      r = $urandom_range(0, 99);
      b = BYTE_BITS'($urandom_range(0, 255));
      if (r < 30) begin
         for (int k = 0; k < 16; k++) begin
            if (sep_copy[b[7:6]][b[5:0]])
               break;
            b = BYTE_BITS'($urandom_range(0, 255));
         end
      end else if (r < 55) begin
         r = $urandom_range(0, 5);
         b = (r == 5) ? WS_SPACE : WS_TAB + r[BYTE_BITS-1:0];
      end
      return b;
   endfunction

   initial begin
      int          str_left;
      int          n_items;
      int          style;
      logic [63:0] m0;
      logic [5:0]  bit_idx;
      logic        trim;
      logic        drop;
      logic        fin;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: no separators, no trim
      send_item(CHR_A, 1'b0);
      send_item(WS_SPACE, 1'b0);
      send_item(CHR_B, 1'b1);
      drain();

      // extreme separator bytes, space and comma as separators, trim on
      load_config((64'd1 << CHR_NUL) | (64'd1 << WS_SPACE) | (64'd1 << CHR_COMMA),
                  '0, '0, 64'd1 << 63, 1'b1, 1'b0);
      send_item(CHR_NUL, 1'b0);
      send_item(CHR_TOP, 1'b0);
      send_item(CHR_X, 1'b0);
      send_item(CHR_COMMA, 1'b1);        // separator as the final byte
      send_item(WS_SPACE, 1'b0);         // leading whitespace that is also a separator
      send_item(WS_TAB, 1'b0);
      send_item(CHR_A, 1'b0);
      send_item(WS_SPACE, 1'b0);
      send_item(CHR_COMMA, 1'b0);
      send_item(WS_SPACE, 1'b0);
      send_item(CHR_B, 1'b0);
      send_item(WS_SPACE, 1'b1);         // trailing whitespace at string end
      send_item(CHR_COMMA, 1'b1);
      send_item(WS_SPACE, 1'b1);
      send_item(CHR_HIGH, 1'b1);         // high byte is never whitespace
      drain();

      // drop empty on, trim off, then trim switched on inside a string
      load_config(64'd1 << CHR_COMMA, '0, '0, '0, 1'b0, 1'b1);
      send_item(CHR_COMMA, 1'b0);
      send_item(WS_SPACE, 1'b0);
      send_item(CHR_A, 1'b0);
      drain();
      write_csr(CSR_TRIM, 64'd1);
      send_item(WS_SPACE, 1'b0);
      send_item(CHR_LF, 1'b1);
      drain();

      // random phases; strings run across phase boundaries
      str_left = 0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         style = (p == 0) ? 0 : (p == 1) ? 1 : ($urandom_range(0, 3) == 0) ? 2 : 3;
         m0 = rand_map(style);
         if (style == 3 && $urandom_range(0, 1) == 1) begin
            bit_idx = ($urandom_range(0, 5) == 5) ? 6'd32 : 6'($urandom_range(9, 13));
            m0[bit_idx] = 1'b1;
         end
         if (p < 4) begin
            trim = p[0];
            drop = p[1];
         end else begin
            trim = 1'($urandom_range(0, 1));
            drop = 1'($urandom_range(0, 1));
         end
         if (p == 3) begin
            write_csr(CSR_SPARE_6, {$urandom, $urandom});
            write_csr(CSR_SPARE_7, {$urandom, $urandom});
         end
         load_config(m0, rand_map(style), rand_map(style), rand_map(style), trim, drop);
         burst_min = 1;
         burst_max = 16;
         gap_max   = (p == 2) ? 0 : 6;
         n_items   = $urandom_range(50, 75);
         for (int i = 0; i < n_items; i++) begin
            if (str_left == 0)
               str_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10)
                                                       : $urandom_range(11, 40);
            fin = (str_left == 1);
            str_left--;
            send_item(pick_byte(), fin);
         end
      end

      // one last short string with comma separators and trim on
      drain();
      load_config(64'd1 << CHR_COMMA, '0, '0, '0, 1'b1, 1'b0);
      send_item(CHR_A, 1'b0);
      send_item(CHR_COMMA, 1'b0);
      send_item(CHR_B, 1'b1);

      // wait out the last tokens
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("PASS separator_tokenizer_with_trim_top");
      else
         $display("FAIL separator_tokenizer_with_trim_top");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("FAIL separator_tokenizer_with_trim_top");
      $finish;
   end

endmodule

>>> filelist.f
design/septok_pkg.sv
design/separator_tokenizer_with_trim_top.sv
tb/separator_tokenizer_with_trim_checker.sv
tb/separator_tokenizer_with_trim_top_tb.sv
